[sv/assert_macros.svh]
// Assertion macros used by the top-level RTL file of the line rasterizer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/dda_pkg.sv]
// Shared types and constants of the line rasterizer.
package dda_pkg;

  // Opcodes carried in the input tuser field.
  localparam logic [1:0] OP_STEP  = 2'd0;
  localparam logic [1:0] OP_RIGHT = 2'd1;
  localparam logic [1:0] OP_LEFT  = 2'd2;

  // Register indexes, taken from paddr[3:2].
  localparam logic [1:0] REG_ROW_BYTES = 2'd0;
  localparam logic [1:0] REG_BPP       = 2'd1;
  localparam logic [1:0] REG_COLOR     = 2'd2;

  // Register reset values.
  localparam logic [15:0] ROW_BYTES_RESET = 16'd4096;
  localparam logic [3:0]  BPP_RESET       = 4'd4;
  localparam logic [31:0] COLOR_RESET     = 32'h00FF_FFFF;

  // Status of a serial arithmetic unit.
  typedef struct packed {
    logic busy;
    logic done;
  } unit_status_t;

endpackage

[sv/dda_line_segment_rasterizer.sv]
// Top level of the DDA line segment rasterizer.
//
// Input stream (s_*): one beat per item. s_tuser holds the opcode (step,
// load rightward, load leftward); s_tdata holds x_start, y_start, x_end and
// y_end. Output stream (m_*): one beat per drawn pixel with x, rounded y,
// byte offset and colour in m_tdata and the end-of-segment flag in m_tlast.
// Registers row_bytes, bytes_per_pixel and draw_color sit on the APB port
// at byte addresses 0, 4 and 8; write them only while the block is idle.
//
// A load runs the bit-serial slope divider (one quotient bit per cycle). A
// step that draws runs the bit-serial offset unit before its pixel reaches
// the output register. Items are handled one at a time; s_tready is high
// whenever no item is in work, even while a pixel waits on m_tready. A
// stalled receiver holds the finished pixel in the output register and the
// next drawing step waits for it to leave. Reset clears the segment, empties
// the output register and restores the register reset values.
`include "assert_macros.svh"

module dda_line_segment_rasterizer #(
  parameter int COORD_BITS    = 12,
  parameter int FRACTION_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  // tdata: x_start, y_start, x_end, y_end (from bit 0 up), zero padded
  input  logic                                    s_tvalid,
  output logic                                    s_tready,
  input  logic [((4*COORD_BITS+7)/8)*8-1:0]       s_tdata,
  // tuser: opcode
  input  logic [1:0]                              s_tuser,
  // tdata: pixel_x, pixel_y, byte_offset, pixel_color (from bit 0 up), zero padded
  output logic                                    m_tvalid,
  input  logic                                    m_tready,
  output logic [((2*COORD_BITS+64+7)/8)*8-1:0]    m_tdata,
  output logic                                    m_tlast,
  // Configuration port
  input  logic                                    psel,
  input  logic                                    penable,
  input  logic                                    pwrite,
  input  logic [3:0]                              paddr,
  input  logic [31:0]                             pwdata,
  output logic [31:0]                             prdata,
  output logic                                    pready
);

  localparam int C     = COORD_BITS;
  localparam int F     = FRACTION_BITS;
  localparam int QW    = C + F;
  localparam int AW    = C + F + 1;
  localparam int OUT_W = ((2*COORD_BITS+64+7)/8)*8;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIV  = 5'b00010,
    S_RND  = 5'b00100,
    S_MUL  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t state;

  // Configuration registers.
  logic [15:0] row_bytes;
  logic [3:0]  bytes_per_pixel;
  logic [31:0] draw_color;

  // Segment state.
  logic                segment_active;
  logic                step_left;
  logic [C-1:0]        current_x;
  logic [C-1:0]        target_x;
  logic [AW-1:0]       y_accumulator;
  logic [AW-1:0]       y_increment;
  logic                slope_neg;
  logic                last_flag;
  logic [C-1:0]        round_y;

  // Output register.
  logic [C-1:0]        out_x;
  logic [C-1:0]        out_y;
  logic [31:0]         out_offset;
  logic [31:0]         out_color;
  logic                out_last;
  logic                out_valid;

  // Unit interfaces.
  logic                   div_start;
  logic [QW-1:0]          quotient;
  dda_pkg::unit_status_t  div_st;
  logic                   mul_start;
  logic [31:0]            mul_offset;
  dda_pkg::unit_status_t  mul_st;

  // Input field views and load arithmetic.
  logic [1:0]    op;
  logic [C-1:0]  xs;
  logic [C-1:0]  ys;
  logic [C-1:0]  xe;
  logic [C-1:0]  ye;
  logic          op_load;
  logic          op_left;
  logic [C:0]    dx;
  logic          dx_ok;
  logic [C:0]    dy;
  logic [C:0]    dy_mag;
  logic          accept;
  logic          cfg_write;
  logic [C-1:0]  x_next;
  logic [AW-1:0] rnd_sum;
  logic [AW-1:0] half_fix;
  logic          out_free;
  logic          out_load;

  assign op = s_tuser;
  assign xs = s_tdata[C-1:0];
  assign ys = s_tdata[2*C-1:C];
  assign xe = s_tdata[3*C-1:2*C];
  assign ye = s_tdata[4*C-1:3*C];

  // Direction check and slope operands of a load.
  always_comb begin
    op_load = (op == dda_pkg::OP_RIGHT) || (op == dda_pkg::OP_LEFT);
    op_left = (op == dda_pkg::OP_LEFT);
    dx      = op_left ? ({xs[C-1], xs} - {xe[C-1], xe})
                      : ({xe[C-1], xe} - {xs[C-1], xs});
    dx_ok   = !dx[C] && (dx != '0);
    dy      = {ye[C-1], ye} - {ys[C-1], ys};
    dy_mag  = dy[C] ? (~dy + 1'b1) : dy;
  end

  assign s_tready  = (state == S_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign div_start = accept && op_load && dx_ok;
  assign out_free  = !out_valid || m_tready;
  assign out_load  = (state == S_OUT) && out_free;

  // Next x and rounding of the accumulator, half away from zero.
  always_comb begin
    x_next   = step_left ? (current_x - 1'b1) : (current_x + 1'b1);
    half_fix = {{(AW-F){1'b0}}, 1'b1, {(F-1){1'b0}}};
    rnd_sum  = y_accumulator + half_fix - {{(AW-1){1'b0}}, y_accumulator[AW-1]};
    round_y  = rnd_sum[F+C-1:F];
  end

  assign mul_start = (state == S_RND);

  dda_div #(
    .NUM_BITS (QW),
    .DEN_BITS (C)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({dy_mag[C-1:0], {F{1'b0}}}),
    .divisor  (dx[C-1:0]),
    .quotient (quotient),
    .status   (div_st)
  );

  dda_mul #(
    .COORD_BITS (C)
  ) u_mul (
    .clk             (clk),
    .rst             (rst),
    .start           (mul_start),
    .coord_y         (round_y),
    .coord_x         (current_x),
    .row_bytes       (row_bytes),
    .bytes_per_pixel (bytes_per_pixel),
    .offset          (mul_offset),
    .status          (mul_st)
  );

  // Sequencer and segment state. The rounded y and the offset stay put in
  // their sources until the pixel is loaded, so a waiting beat is untouched.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      segment_active <= 1'b0;
      step_left      <= 1'b0;
      current_x      <= '0;
      target_x       <= '0;
      y_accumulator  <= '0;
      y_increment    <= '0;
      slope_neg      <= 1'b0;
      last_flag      <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept && op_load) begin
            segment_active <= dx_ok;
            if (dx_ok) begin
              step_left     <= op_left;
              current_x     <= xs;
              target_x      <= xe;
              y_accumulator <= {ys[C-1], ys, {F{1'b0}}};
              slope_neg     <= dy[C];
              state         <= S_DIV;
            end
          end else if (accept && (op == dda_pkg::OP_STEP) && segment_active) begin
            current_x     <= x_next;
            y_accumulator <= y_accumulator + y_increment;
            last_flag     <= (x_next == target_x);
            if (x_next == target_x) begin
              segment_active <= 1'b0;
            end
            state <= S_RND;
          end
        end
        S_DIV: begin
          if (div_st.done) begin
            y_increment <= slope_neg ? (~{1'b0, quotient} + 1'b1) : {1'b0, quotient};
            state       <= S_IDLE;
          end
        end
        S_RND: begin
          state <= S_MUL;
        end
        S_MUL: begin
          if (mul_st.done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_x      <= current_x;
            out_y      <= round_y;
            out_offset <= mul_offset;
            out_color  <= draw_color;
            out_last   <= last_flag;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output beat valid: set when a pixel is loaded, cleared when it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tlast  = out_last;
  assign m_tdata  = OUT_W'({out_color, out_offset, out_y, out_x});

  // Configuration registers.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_bytes       <= dda_pkg::ROW_BYTES_RESET;
      bytes_per_pixel <= dda_pkg::BPP_RESET;
      draw_color      <= dda_pkg::COLOR_RESET;
    end else if (cfg_write) begin
      case (paddr[3:2])
        dda_pkg::REG_ROW_BYTES: row_bytes       <= pwdata[15:0];
        dda_pkg::REG_BPP:       bytes_per_pixel <= pwdata[3:0];
        dda_pkg::REG_COLOR:     draw_color      <= pwdata;
        default: begin
        end
      endcase
    end
  end

  // Register read back.
  always_comb begin
    case (paddr[3:2])
      dda_pkg::REG_ROW_BYTES: prdata = {16'd0, row_bytes};
      dda_pkg::REG_BPP:       prdata = {28'd0, bytes_per_pixel};
      dda_pkg::REG_COLOR:     prdata = draw_color;
      default:                prdata = 32'd0;
    endcase
  end

  // The divider reports only while the sequencer waits for it.
  `ASSERT_CLK(a_div_done_in_div, div_st.done |-> (state == S_DIV), "divider done outside divide")
  // The offset unit reports only while the sequencer waits for it.
  `ASSERT_CLK(a_mul_done_in_mul, mul_st.done |-> (state == S_MUL), "offset done outside multiply")
  // An item is taken only with both serial units at rest.
  `ASSERT_CLK(a_units_idle_on_take, s_tready |-> (!div_st.busy && !mul_st.busy), "unit busy at input")

endmodule

[sv/dda_div.sv]
// Bit-serial restoring divider, one quotient bit per cycle.
module dda_div #(
  parameter int NUM_BITS = 28,
  parameter int DEN_BITS = 12
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [NUM_BITS-1:0]       dividend,
  input  logic [DEN_BITS-1:0]       divisor,
  output logic [NUM_BITS-1:0]       quotient,
  output dda_pkg::unit_status_t     status
);

  localparam int CW = $clog2(NUM_BITS + 1);

  logic [NUM_BITS-1:0] shreg;
  logic [DEN_BITS-1:0] rem;
  logic [DEN_BITS-1:0] den;
  logic [CW-1:0]       count;
  logic                busy;
  logic                done;
  logic [DEN_BITS:0]   trial;
  logic [DEN_BITS:0]   diff;
  logic                fits;

  // Trial subtraction of the divisor from the partial remainder.
  always_comb begin
    trial = {rem, shreg[NUM_BITS-1]};
    diff  = trial - {1'b0, den};
    fits  = !diff[DEN_BITS];
  end

  // The dividend shifts out at the top while quotient bits shift in below.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
        shreg <= dividend;
        rem   <= '0;
        den   <= divisor;
      end else if (busy) begin
        shreg <= {shreg[NUM_BITS-2:0], fits};
        rem   <= fits ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
        count <= count + 1'b1;
        if (count == CW'(NUM_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient    = shreg;
  assign status.busy = busy;
  assign status.done = done;

endmodule

[sv/dda_mul.sv]
// Bit-serial offset unit: py*row_bytes + x*bytes_per_pixel, one bit pair per cycle.
module dda_mul #(
  parameter int COORD_BITS = 12
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [COORD_BITS-1:0]   coord_y,
  input  logic [COORD_BITS-1:0]   coord_x,
  input  logic [15:0]             row_bytes,
  input  logic [3:0]              bytes_per_pixel,
  output logic [31:0]             offset,
  output dda_pkg::unit_status_t   status
);

  localparam int CW = (COORD_BITS > 1) ? $clog2(COORD_BITS) : 1;

  logic [COORD_BITS-1:0] my;
  logic [COORD_BITS-1:0] mx;
  logic [31:0]           ca;
  logic [31:0]           cb;
  logic [31:0]           acc;
  logic [CW-1:0]         count;
  logic                  busy;
  logic                  done;
  logic [31:0]           ta;
  logic [31:0]           tb;
  logic [31:0]           acc_next;
  logic                  sign_bit;

  // Partial products of this bit; the sign bit of each coordinate weighs negative.
  always_comb begin
    ta       = my[0] ? ca : 32'd0;
    tb       = mx[0] ? cb : 32'd0;
    sign_bit = (count == CW'(COORD_BITS - 1));
    acc_next = sign_bit ? (acc - ta - tb) : (acc + ta + tb);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
        my    <= coord_y;
        mx    <= coord_x;
        ca    <= {16'd0, row_bytes};
        cb    <= {28'd0, bytes_per_pixel};
        acc   <= '0;
      end else if (busy) begin
        my    <= my >> 1;
        mx    <= mx >> 1;
        ca    <= ca << 1;
        cb    <= cb << 1;
        acc   <= acc_next;
        count <= count + 1'b1;
        if (sign_bit) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign offset      = acc;
  assign status.busy = busy;
  assign status.done = done;

endmodule

[dv/dda_line_segment_rasterizer_tb.sv]
// Self-checking testbench for the DDA line segment rasterizer stream block.
module dda_line_segment_rasterizer_tb;

  localparam int CYCLE_LIMIT = 600000;
  // Wait after the last owed pixel so that a pending load has finished.
  localparam int SETTLE_CYCLES = 40;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam longint FIX_ONE  = 65536;
  localparam longint FIX_HALF = 32768;

  typedef struct packed {
    logic signed [11:0] x;
    logic signed [11:0] y;
    logic [31:0]        offset;
    logic [31:0]        color;
    logic               last;
  } pixel_t;

  // Tracks the segment state and register copies, and holds the pixels
  // that the block owes on its output stream.
  class pixel_scoreboard;
    longint line_len = dda_pkg::ROW_BYTES_RESET;
    longint bpp = dda_pkg::BPP_RESET;
    logic [31:0] color = dda_pkg::COLOR_RESET;
    bit active;
    bit left;
    int cur_x;
    int end_x;
    longint y_acc;
    longint y_inc;
    pixel_t owed[$];
    int errors;

    function void set_register(logic [1:0] idx, logic [31:0] value);
      case (idx)
        dda_pkg::REG_ROW_BYTES: line_len = value[15:0];
        dda_pkg::REG_BPP: bpp = value[3:0];
        dda_pkg::REG_COLOR: color = value;
        default: ;
      endcase
    endfunction

    // Advances the segment for one accepted input beat.
    function void accept_item(logic [1:0] op, logic [47:0] data);
      logic signed [11:0] xs, ys, xe, ye;
      longint dx, py, off;
      pixel_t px;
      xs = data[11:0];
      ys = data[23:12];
      xe = data[35:24];
      ye = data[47:36];
      if (op == dda_pkg::OP_RIGHT || op == dda_pkg::OP_LEFT) begin
        dx = (op == dda_pkg::OP_LEFT) ? longint'(xs) - longint'(xe)
                                      : longint'(xe) - longint'(xs);
        if (dx <= 0) begin
          // Wrong direction: drop the segment, keep the rest of the state.
          active = 1'b0;
        end else begin
          active = 1'b1;
          left = (op == dda_pkg::OP_LEFT);
          cur_x = xs;
          end_x = xe;
          y_acc = longint'(ys) * FIX_ONE;
          y_inc = (longint'(ye) - longint'(ys)) * FIX_ONE / dx;
        end
      end else if (op == dda_pkg::OP_STEP && active) begin
        cur_x = left ? cur_x - 1 : cur_x + 1;
        y_acc = y_acc + y_inc;
        // Round half away from zero.
        if (y_acc >= 0) py = (y_acc + FIX_HALF) / FIX_ONE;
        else py = -((-y_acc + FIX_HALF) / FIX_ONE);
        off = py * line_len + longint'(cur_x) * bpp;
        px.x = cur_x[11:0];
        px.y = py[11:0];
        px.offset = off[31:0];
        px.color = color;
        px.last = (cur_x == end_x);
        if (px.last) active = 1'b0;
        owed.push_back(px);
      end
    endfunction

    function void report(string field, longint want, longint got);
      errors++;
      $display("%0t: %s mismatch, expected %0d (0x%0h), actual %0d (0x%0h)",
               $time, field, want, want, got, got);
    endfunction

    // Compares one output beat with the oldest owed pixel.
    function void check_pixel(logic [87:0] data, logic last);
      pixel_t got, want;
      got.x = data[11:0];
      got.y = data[23:12];
      got.offset = data[55:24];
      got.color = data[87:56];
      got.last = last;
      if (owed.size() == 0) begin
        errors++;
        $display("%0t: unexpected pixel, expected none, actual x=%0d y=%0d offset=0x%0h",
                 $time, got.x, got.y, got.offset);
        return;
      end
      want = owed.pop_front();
      if (got.x !== want.x) report("pixel_x", want.x, got.x);
      if (got.y !== want.y) report("pixel_y", want.y, got.y);
      if (got.offset !== want.offset) report("byte_offset", want.offset, got.offset);
      if (got.color !== want.color) report("pixel_color", want.color, got.color);
      if (got.last !== want.last) report("last_pixel", want.last, got.last);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  // tdata: x_start, y_start, x_end, y_end (from bit 0 up)
  logic [47:0] s_tdata;
  // tuser: opcode
  logic [1:0] s_tuser;
  logic m_tvalid;
  logic m_tready;
  // tdata: pixel_x, pixel_y, byte_offset, pixel_color (from bit 0 up)
  logic [87:0] m_tdata;
  logic m_tlast;
  logic psel;
  logic penable;
  logic pwrite;
  logic [3:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  pixel_scoreboard board = new;
  int tx_max = 6;
  int tx_items;
  int cycle_count = 0;

  dda_line_segment_rasterizer dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Sends one input beat after a random gap; tvalid stays high when the
  // next beat follows without a gap.
  task automatic send_item(input logic [1:0] op, input int xs, input int ys,
                           input int xe, input int ye);
    int gap;
    if (tx_items % 64 == 0) tx_max = ($urandom_range(0, 2) == 0) ? 0 : 6;
    tx_items++;
    gap = $urandom_range(0, tx_max);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {ye[11:0], xe[11:0], ys[11:0], xs[11:0]};
    do @(posedge clk); while (!s_tready);
    board.accept_item(op, {ye[11:0], xe[11:0], ys[11:0], xs[11:0]});
  endtask

  task automatic step();
    send_item(dda_pkg::OP_STEP, $urandom, $urandom, $urandom, $urandom);
  endtask

  // Holds the input until every owed pixel is out and the block is idle.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (board.owed.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    board.set_register(idx, value);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  function automatic int any_coord();
    return int'($urandom_range(0, 4095)) - 2048;
  endfunction

  // Mostly complete segments with random content, with some interrupted
  // segments, unchecked loads and stray beats mixed in.
  task automatic run_random(input int count);
    int sent, choice, len, k, xs, xe, ys, ye;
    bit go_left;
    sent = 0;
    while (sent < count) begin
      choice = $urandom_range(0, 9);
      if (choice <= 6) begin
        go_left = 1'($urandom_range(0, 1));
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 4095) : $urandom_range(1, 12);
        xs = any_coord();
        if (!go_left) begin
          if (xs + len > 2047) xs = 2047 - len;
          xe = xs + len;
        end else begin
          if (xs - len < -2048) xs = -2048 + len;
          xe = xs - len;
        end
        ys = any_coord();
        ye = ($urandom_range(0, 3) == 0) ? ys : any_coord();
        send_item(go_left ? dda_pkg::OP_LEFT : dda_pkg::OP_RIGHT, xs, ys, xe, ye);
        if (len > 40) k = $urandom_range(1, 40);
        else if ($urandom_range(0, 4) == 0) k = $urandom_range(0, len);
        else k = len + $urandom_range(0, 1);
        repeat (k) step();
        sent += k + 1;
      end else if (choice == 7) begin
        send_item(2'($urandom_range(1, 2)), $urandom, $urandom, $urandom, $urandom);
        k = $urandom_range(0, 3);
        repeat (k) step();
        sent += k + 1;
      end else if (choice == 8) begin
        repeat ($urandom_range(1, 3)) step();
      end else begin
        send_item(OP_UNUSED, $urandom, $urandom, $urandom, $urandom);
      end
      // Occasionally let the output side run completely dry.
      if ($urandom_range(0, 49) == 0) drain();
    end
  endtask

  // Output side: random stalls, checks every beat taken.
  initial begin
    int stall;
    int beats;
    int rx_max;
    beats = 0;
    rx_max = 6;
    m_tready = 1'b0;
    wait (rst == 1'b0);
    forever begin
      if (beats % 64 == 0) rx_max = ($urandom_range(0, 2) == 0) ? 0 : 6;
      stall = $urandom_range(0, rx_max);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      board.check_pixel(m_tdata, m_tlast);
      beats++;
    end
  end

  // Main sequence.
  initial begin
    logic [15:0] ll;
    logic [3:0] bpp;
    logic [31:0] color;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = dda_pkg::OP_STEP;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    tx_items = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed beats with the reset register values.
    step();                                   // no segment yet
    send_item(OP_UNUSED, $urandom, $urandom, $urandom, $urandom);
    send_item(dda_pkg::OP_RIGHT, -2048, 2047, 2047, -2048);
    step();
    step();
    send_item(dda_pkg::OP_LEFT, 2047, -2048, -2048, 2047);
    step();
    step();
    // Steepest slopes, one pixel long.
    send_item(dda_pkg::OP_RIGHT, 0, -2048, 1, 2047);
    step();
    step();
    send_item(dda_pkg::OP_LEFT, 0, 2047, -1, -2048);
    step();
    // Loads against their direction are dropped.
    send_item(dda_pkg::OP_RIGHT, 5, 0, 5, 3);
    step();
    send_item(dda_pkg::OP_LEFT, 5, 0, 6, 3);
    step();
    // Half-pixel slopes exercise rounding on both signs.
    send_item(dda_pkg::OP_RIGHT, 0, 0, 2, 1);
    step();
    step();
    send_item(dda_pkg::OP_RIGHT, 0, 0, 2, -1);
    step();
    step();
    run_random(200);

    for (int phase = 1; phase < 8; phase++) begin
      drain();
      case (phase)
        1: begin ll = 16'd1; bpp = 4'd0; color = 32'h0; end
        2: begin ll = 16'hFFFF; bpp = 4'hF; color = 32'hFFFF_FFFF; end
        3: begin ll = 16'd1; bpp = 4'd8; color = $urandom; end
        4: begin ll = 16'hFFFF; bpp = 4'd1; color = $urandom; end
        default: begin
          ll = 16'($urandom_range(1, 65535));
          bpp = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                            : 4'($urandom_range(1, 8));
          color = $urandom;
        end
      endcase
      write_register(dda_pkg::REG_ROW_BYTES, {16'h0, ll});
      write_register(dda_pkg::REG_BPP, {28'h0, bpp});
      write_register(dda_pkg::REG_COLOR, color);
      run_random(200);
    end

    drain();
    if (board.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
